// File: rtl/bds_pkg.sv
// Shared types, constants and helper functions of the box downsampler.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int COL_W    = 12;   // column or row position, 0 .. MAX_SIDE-1
    localparam int SIDE_W   = 13;   // side length, 1 .. MAX_SIDE
    localparam int K_W      = 4;    // log2 of the reduction factor, 0 .. 13
    localparam int F_W      = 14;   // reduction factor, up to 8192
    localparam int CH_W     = 8;    // one color channel
    localparam int N_W      = 25;   // pixels per block, up to MAX_SIDE squared
    localparam int SUM_W    = 32;   // block sum of one channel
    localparam int LANES    = 4;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIDE_LIMIT   = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 13'd1024;

    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [K_W-1:0]    k;
        logic [N_W-1:0]    n;
    } geom_t;

    typedef struct packed {
        logic             rd;
        logic             acc;
        logic             first;
        logic             step;
        logic [COL_W-1:0] addr;
    } lane_ctrl_t;

    // A zero side counts as 1 and a side above MAX_SIDE counts as MAX_SIDE.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (v > SIDE_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bds_geom.sv
// Configuration registers and the derived image geometry of the box downsampler.
`timescale 1ns / 1ps
`default_nettype none

module bds_geom (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [bds_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [bds_pkg::SIDE_W-1:0] cfg_data,
    output bds_pkg::geom_t                  geom,
    output logic [bds_pkg::SIDE_W-1:0]      w_live,
    output logic [bds_pkg::SIDE_W-1:0]      h_live,
    output logic                            restart
);

    logic [bds_pkg::SIDE_W-1:0] width_reg;
    logic [bds_pkg::SIDE_W-1:0] height_reg;
    logic [bds_pkg::SIDE_W-1:0] limit_reg;
    logic [bds_pkg::SIDE_W-1:0] w_reg;
    logic [bds_pkg::SIDE_W-1:0] h_reg;
    logic [bds_pkg::K_W-1:0]    k_reg;
    logic [bds_pkg::K_W-1:0]    k_next;
    logic [bds_pkg::N_W-1:0]    n_reg;
    logic [bds_pkg::SIDE_W-1:0] longer;
    logic [bds_pkg::F_W-1:0]    factor;
    logic [bds_pkg::SIDE_W-1:0] bw;
    logic [bds_pkg::SIDE_W-1:0] bh;
    logic [bds_pkg::F_W-1:0]    fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bds_pkg::SIDE_RESET;
            height_reg <= bds_pkg::SIDE_RESET;
            limit_reg  <= bds_pkg::SIDE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bds_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bds_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                bds_pkg::REG_SIDE_LIMIT:   limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = cfg_write_en && (cfg_index == bds_pkg::REG_IMAGE_WIDTH
                                   || cfg_index == bds_pkg::REG_IMAGE_HEIGHT
                                   || cfg_index == bds_pkg::REG_SIDE_LIMIT);

    assign w_live = bds_pkg::eff_side(width_reg);
    assign h_live = bds_pkg::eff_side(height_reg);
    assign longer = (w_live > h_live) ? w_live : h_live;

    // The smallest shift that brings the longer side within the limit.
    always_comb
    begin
        for (int i = 0; i < bds_pkg::F_W; i++)
        begin
            fits[i] = (longer >> i) <= limit_reg;
        end
        k_next = bds_pkg::K_W'(bds_pkg::F_W - 1);
        for (int i = bds_pkg::F_W - 1; i >= 0; i--)
        begin
            if (fits[i])
            begin
                k_next = bds_pkg::K_W'(i);
            end
        end
    end

    assign factor = bds_pkg::F_W'(1) << k_reg;
    assign bw = ({1'b0, w_reg} < factor) ? w_reg : factor[bds_pkg::SIDE_W-1:0];
    assign bh = ({1'b0, h_reg} < factor) ? h_reg : factor[bds_pkg::SIDE_W-1:0];

    always_ff @(posedge clk)
    begin
        w_reg <= w_live;
        h_reg <= h_live;
        k_reg <= k_next;
        n_reg <= bds_pkg::N_W'(bw * bh);
    end

    assign geom.w = w_reg;
    assign geom.h = h_reg;
    assign geom.k = k_reg;
    assign geom.n = n_reg;

endmodule

`default_nettype wire

// File: rtl/bds_lane.sv
// One channel lane: per-column block sums in a memory and an iterative mean divider.
`timescale 1ns / 1ps
`default_nettype none

module bds_lane (
    input  wire logic                     clk,
    input  wire bds_pkg::lane_ctrl_t      ctrl,
    input  wire logic [bds_pkg::CH_W-1:0] pix,
    input  wire logic [bds_pkg::N_W-1:0]  n,
    output logic [bds_pkg::CH_W-1:0]      mean
);

    logic [bds_pkg::SUM_W-1:0] mem [0:bds_pkg::MAX_SIDE-1];
    logic [bds_pkg::SUM_W-1:0] rd_reg;
    logic [bds_pkg::SUM_W-1:0] rem_reg;
    logic [bds_pkg::SUM_W-1:0] div_reg;
    logic [bds_pkg::CH_W-1:0]  q_reg;
    logic [bds_pkg::SUM_W-1:0] sum;

    // The first pixel of a block starts from zero, whatever the entry holds.
    assign sum = (ctrl.first ? '0 : rd_reg) + bds_pkg::SUM_W'(pix);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_reg <= mem[ctrl.addr];
        end
        if (ctrl.acc)
        begin
            mem[ctrl.addr] <= sum;
        end
    end

    // Restoring division: the mean fits in CH_W bits, one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.acc)
        begin
            rem_reg <= sum;
            div_reg <= {n, (bds_pkg::CH_W - 1)'(0)};
            q_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_reg <= rem_reg - div_reg;
                q_reg   <= {q_reg[bds_pkg::CH_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[bds_pkg::CH_W-2:0], 1'b0};
            end
            div_reg <= div_reg >> 1;
        end
    end

    assign mean = q_reg;

endmodule

`default_nettype wire

// File: rtl/bds_merge.sv
// Output register that joins the four lane means and the end-of-image flag.
`timescale 1ns / 1ps
`default_nettype none

module bds_merge (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      load,
    input  wire logic [bds_pkg::LANES-1:0][bds_pkg::CH_W-1:0] means,
    input  wire logic                                      done,
    output logic                                           ready,
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic [bds_pkg::CH_W-1:0]                       red_out,
    output logic [bds_pkg::CH_W-1:0]                       green_out,
    output logic [bds_pkg::CH_W-1:0]                       blue_out,
    output logic [bds_pkg::CH_W-1:0]                       alpha_out,
    output logic                                           image_done
);

    logic                                            valid_reg;
    logic [bds_pkg::LANES-1:0][bds_pkg::CH_W-1:0]    data_reg;
    logic                                            done_reg;

    assign ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            data_reg <= means;
            done_reg <= done;
        end
    end

    assign out_valid  = valid_reg;
    assign red_out    = data_reg[0];
    assign green_out  = data_reg[1];
    assign blue_out   = data_reg[2];
    assign alpha_out  = data_reg[3];
    assign image_done = done_reg;

endmodule

`default_nettype wire

// File: rtl/box_downsample_rgba8.sv
// Top level of the power-of-two box-filter downsampler for an RGBA8 raster stream.
`timescale 1ns / 1ps
`default_nettype none

// The block takes source pixels in raster order, one per transfer, and shrinks
// the image by the smallest power of two that brings its longer side within
// longest_side_limit. Each output pixel is the truncated mean of its block per
// channel and leaves on the transfer after the last pixel of that block has
// arrived; image_done marks the final output pixel of the image. Pixels outside
// the covered area are dropped, and a reduction factor of 1 passes pixels
// through. One pixel is worked on at a time: a pixel outside the covered area
// passes through capture and position check, a pixel that joins a block without
// closing it through capture, sum memory read and sum update, and a pixel that
// closes a block also through an 8-step restoring divider that the four channel
// lanes run before the result enters the output register. A closing pixel also
// waits for as long as the output register still holds an earlier result that
// the receiver stalls. The output register lets the next pixel in while a result
// still waits. Writing a register restarts the image at the top left corner; no
// clearing pass is needed, as the first pixel of every block starts its sums
// from zero. A register write takes effect for the very next pixel transfer.
module box_downsample_rgba8 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [bds_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [bds_pkg::SIDE_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [bds_pkg::CH_W-1:0]   red_in,
    input  wire logic [bds_pkg::CH_W-1:0]   green_in,
    input  wire logic [bds_pkg::CH_W-1:0]   blue_in,
    input  wire logic [bds_pkg::CH_W-1:0]   alpha_in,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [bds_pkg::CH_W-1:0]        red_out,
    output logic [bds_pkg::CH_W-1:0]        green_out,
    output logic [bds_pkg::CH_W-1:0]        blue_out,
    output logic [bds_pkg::CH_W-1:0]        alpha_out,
    output logic                            image_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int W  = bds_pkg::SIDE_W;
    localparam int CW = bds_pkg::COL_W;

    bds_pkg::geom_t      geom;
    bds_pkg::lane_ctrl_t lane_ctrl;
    logic [W-1:0]        w_live;
    logic [W-1:0]        h_live;
    logic                restart;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [2:0]          div_cnt_reg;
    logic [CW-1:0]       cnt_c_reg;
    logic [CW-1:0]       cnt_r_reg;
    logic [CW-1:0]       pos_c_reg;
    logic [CW-1:0]       pos_r_reg;
    logic [bds_pkg::LANES-1:0][bds_pkg::CH_W-1:0] pix_reg;
    logic [CW-1:0]       addr_reg;
    logic                first_reg;
    logic                last_reg;
    logic                done_reg;

    logic                accept;
    logic                merge_ready;
    logic                merge_load;
    logic [bds_pkg::LANES-1:0][bds_pkg::CH_W-1:0] means;

    // Block geometry of the captured pixel.
    logic [CW-1:0]       xq;
    logic [CW-1:0]       yq;
    logic [W-1:0]        ow;
    logic [W-1:0]        oh;
    logic [W-1:0]        w_shr;
    logic [W-1:0]        h_shr;
    logic [bds_pkg::F_W-1:0] factor;
    logic [W-1:0]        fm1;
    logic [W-1:0]        cw;
    logic [W-1:0]        ch;
    logic [W-1:0]        pc;
    logic [W-1:0]        pr;
    logic                in_area;
    logic                last_blk;
    logic                first_blk;
    logic                done_blk;

    bds_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .geom         (geom),
        .w_live       (w_live),
        .h_live       (h_live),
        .restart      (restart)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Source position counters clear on a restart, else advance on every transfer and wrap at image end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_c_reg <= '0;
            cnt_r_reg <= '0;
        end
        else if (restart)
        begin
            cnt_c_reg <= '0;
            cnt_r_reg <= '0;
        end
        else if (accept)
        begin
            if ((W'(cnt_c_reg) + W'(1)) >= w_live)
            begin
                cnt_c_reg <= '0;
                cnt_r_reg <= ((W'(cnt_r_reg) + W'(1)) >= h_live) ? '0 : cnt_r_reg + CW'(1);
            end
            else
            begin
                cnt_c_reg <= cnt_c_reg + CW'(1);
            end
        end
    end

    // Output size is the source size over the factor, at least one pixel; the
    // covered area is a whole number of blocks, or the full side when the side
    // is shorter than one block.
    assign factor  = bds_pkg::F_W'(1) << geom.k;
    assign fm1     = W'(factor - bds_pkg::F_W'(1));
    assign xq      = pos_c_reg >> geom.k;
    assign yq      = pos_r_reg >> geom.k;
    assign w_shr   = geom.w >> geom.k;
    assign h_shr   = geom.h >> geom.k;
    assign ow      = (w_shr == '0) ? W'(1) : w_shr;
    assign oh      = (h_shr == '0) ? W'(1) : h_shr;
    assign cw      = ({1'b0, geom.w} < factor) ? geom.w : W'(ow << geom.k);
    assign ch      = ({1'b0, geom.h} < factor) ? geom.h : W'(oh << geom.k);
    assign pc      = W'(pos_c_reg);
    assign pr      = W'(pos_r_reg);
    assign in_area = (W'(xq) < ow) && (W'(yq) < oh);

    // A pixel closes its block when it sits on the block's last column and
    // last row, either at a factor boundary or at the edge of the covered area.
    assign last_blk  = ((pc == cw - W'(1)) || ((pc & fm1) == fm1))
                    && ((pr == ch - W'(1)) || ((pr & fm1) == fm1));
    assign first_blk = ((pc & fm1) == '0) && ((pr & fm1) == '0);
    assign done_blk  = (W'(xq) + W'(1) == ow) && (W'(yq) + W'(1) == oh);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = in_area ? S_ACC : S_IDLE;
            end
            S_ACC:
            begin
                state_next = last_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_cnt_reg == 3'd7)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (merge_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_c_reg  <= cnt_c_reg;
            pos_r_reg  <= cnt_r_reg;
            pix_reg[0] <= red_in;
            pix_reg[1] <= green_in;
            pix_reg[2] <= blue_in;
            pix_reg[3] <= alpha_in;
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg  <= xq;
            first_reg <= first_blk;
            last_reg  <= last_blk;
            done_reg  <= done_blk;
        end
    end

    assign lane_ctrl.rd    = (state_reg == S_ADDR) && in_area;
    assign lane_ctrl.acc   = (state_reg == S_ACC);
    assign lane_ctrl.first = first_reg;
    assign lane_ctrl.step  = (state_reg == S_DIV);
    assign lane_ctrl.addr  = (state_reg == S_ADDR) ? xq : addr_reg;

    for (genvar g = 0; g < bds_pkg::LANES; g++)
    begin : g_lane
        bds_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .pix  (pix_reg[g]),
            .n    (geom.n),
            .mean (means[g])
        );
    end

    assign merge_load = (state_reg == S_OUT);

    bds_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (merge_load),
        .means      (means),
        .done       (done_reg),
        .ready      (merge_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .image_done (image_done)
    );

`ifndef NO_ASSERTIONS
    a_out_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT)
        else $error("result appeared without a finished division");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == 3'd7) |=> state_reg == S_OUT)
        else $error("divider did not finish after eight steps");

    a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> $past(state_reg) == S_ADDR)
        else $error("sum update without a preceding memory read");

    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> geom.k <= bds_pkg::K_W'(bds_pkg::F_W - 1))
        else $error("reduction shift out of range");
`endif

endmodule

`default_nettype wire
